/* design/scma_pkg.sv */
// Package for the sparse COO matrix adder: sizes, codes and the list entry type.
// Depends on nothing; imported by sparse_coo_matrix_add_top.
package scma_pkg;

    // list capacity and coordinate width
    localparam int DEPTH      = 32;
    localparam int COORD_BITS = 16;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // action codes of an input word
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    // status codes of a result word
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    // one stored triple
    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [31:0]           value;
    } t_entry;

endpackage

/* design/sparse_coo_matrix_add_top.sv */
// Sparse COO matrix adder: two triple lists in synchronous RAMs, merged on start.
// Depends on scma_pkg.
//
// A load word (action 0 or 1) appends a triple to list A
// or list B; a full list drops it. A start word compares the dimension
// registers. On a mismatch, or when both lists are empty, one result word
// appears on the cycle after start and busy stays low. Otherwise busy rises,
// and one result word per cycle follows, after the state and strobe registers,
// count_a + count_b - (matching coordinates) words in all, the final one
// marked by o_last. The rate is set by the single read port of each list RAM,
// which fetches the next head of a list every cycle. Results are shown for
// one cycle under o_strobe and cannot be stalled. Configuration writes are
// always taken (o_cfg_ready is high) and belong only to idle periods.
module sparse_coo_matrix_add_top
    import scma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [15:0]        i_row,
    input  logic [15:0]        i_col,
    input  logic signed [31:0] i_value,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // result channel
    output logic               o_strobe,
    output logic [15:0]        o_out_row,
    output logic [15:0]        o_out_col,
    output logic signed [31:0] o_out_value,
    output logic [1:0]         o_status,
    output logic               o_last
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]  r_idx_a, n_idx_a, r_idx_b, n_idx_b;
    logic [15:0]       r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    t_entry            mem_a [DEPTH];
    t_entry            mem_b [DEPTH];
    t_entry            r_rd_a, r_rd_b;
    t_entry            w_entry;
    logic              we_a, we_b;

    logic              r_strobe, n_strobe;
    logic [15:0]       r_out_row, n_out_row, r_out_col, n_out_col;
    logic [31:0]       r_out_value, n_out_value;
    logic [1:0]        r_status, n_status;
    logic              r_last, n_last;

    logic              accept, a_has, b_has, a_lt, a_eq, take_a, take_b;
    logic              dims_match;

    assign accept      = start && !busy;
    assign busy        = (r_state == ST_MERGE);
    assign o_cfg_ready = 1'b1;
    assign dims_match  = (r_rows_a == r_rows_b) && (r_cols_a == r_cols_b);

    assign w_entry.row   = i_row[COORD_BITS-1:0];
    assign w_entry.col   = i_col[COORD_BITS-1:0];
    assign w_entry.value = i_value;

    // head comparison, row first and then column
    assign a_has  = (r_idx_a < r_cnt_a);
    assign b_has  = (r_idx_b < r_cnt_b);
    assign a_lt   = (r_rd_a.row < r_rd_b.row) ||
                    ((r_rd_a.row == r_rd_b.row) && (r_rd_a.col < r_rd_b.col));
    assign a_eq   = (r_rd_a.row == r_rd_b.row) && (r_rd_a.col == r_rd_b.col);
    assign take_a = a_has && (!b_has || a_lt || a_eq);
    assign take_b = b_has && (!a_has || !a_lt);

    // command decode and merge step
    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_strobe    = 1'b0;
        n_out_row   = '0;
        n_out_col   = '0;
        n_out_value = '0;
        n_status    = STAT_OK;
        n_last      = 1'b0;
        we_a        = 1'b0;
        we_b        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx_a = '0;
                n_idx_b = '0;
                if (accept) begin
                    case (i_action)
                        ACT_LOAD_A: begin
                            if (r_cnt_a < CNT_W'(DEPTH)) begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        ACT_LOAD_B: begin
                            if (r_cnt_b < CNT_W'(DEPTH)) begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end
                        end
                        ACT_START: begin
                            if (!dims_match) begin
                                n_strobe = 1'b1;
                                n_status = STAT_MISMATCH;
                                n_last   = 1'b1;
                                n_cnt_a  = '0;
                                n_cnt_b  = '0;
                            end else if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                n_strobe = 1'b1;
                                n_status = STAT_EMPTY;
                                n_last   = 1'b1;
                            end else begin
                                n_state = ST_MERGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE: begin
                n_strobe    = 1'b1;
                n_idx_a     = r_idx_a + CNT_W'(take_a);
                n_idx_b     = r_idx_b + CNT_W'(take_b);
                n_out_row   = 16'(take_a ? r_rd_a.row : r_rd_b.row);
                n_out_col   = 16'(take_a ? r_rd_a.col : r_rd_b.col);
                if (take_a && take_b) begin
                    n_out_value = r_rd_a.value + r_rd_b.value;
                end else if (take_a) begin
                    n_out_value = r_rd_a.value;
                end else begin
                    n_out_value = r_rd_b.value;
                end
                // drop both lists once the last head is out
                if (n_idx_a == r_cnt_a && n_idx_b == r_cnt_b) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_idx_a = '0;
                    n_idx_b = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_idx_a  <= '0;
            r_idx_b  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_idx_a  <= n_idx_a;
            r_idx_b  <= n_idx_b;
            r_strobe <= n_strobe;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= '0;
            r_cols_a <= '0;
            r_rows_b <= '0;
            r_cols_b <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    // list RAMs: write at the fill count, read the next head each cycle
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[r_cnt_a[ADDR_W-1:0]] <= w_entry;
        end
        r_rd_a <= mem_a[n_idx_a[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[r_cnt_b[ADDR_W-1:0]] <= w_entry;
        end
        r_rd_b <= mem_b[n_idx_b[ADDR_W-1:0]];
    end

    assign o_strobe    = r_strobe;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_last      = r_last;

    // a merge never runs with both lists exhausted
    a_merge_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (a_has || b_has))
        else $error("merge active with both lists exhausted");

    // read pointers never pass the fill counts
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx_a <= r_cnt_a) && (r_idx_b <= r_cnt_b))
        else $error("read pointer beyond fill count");

    // a start gives either a result word or a running merge on the next cycle
    a_start_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_START) |=> (busy || o_strobe))
        else $error("start gave no response");

    // status words are always final
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STAT_OK) |-> o_last)
        else $error("status word not marked last");

    // leaving the merge clears both lists
    a_clear_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE && n_state == ST_IDLE) |=> (r_cnt_a == '0 && r_cnt_b == '0))
        else $error("lists not cleared after merge");

endmodule

/* bench/sparse_coo_matrix_add_top_tb.sv */
// Testbench for sparse_coo_matrix_add_top: loads random coordinate lists and merges them,
// predicts every sum word, and checks each result word. Depends on scma_pkg and the top.
`timescale 1ns / 1ps

module sparse_coo_matrix_add_top_tb;
    import scma_pkg::*;

    // unused action code, must be ignored by the block
    localparam logic [1:0] ACT_NONE  = 2'd3;
    localparam int         IDLE_TAIL = 6;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } sum_word_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = ACT_NONE;
    logic [15:0]        i_row = '0;
    logic [15:0]        i_col = '0;
    logic signed [31:0] i_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = REG_ROWS_A;
    logic [15:0]        i_cfg_data = '0;
    logic               o_strobe;
    logic [15:0]        o_out_row;
    logic [15:0]        o_out_col;
    logic signed [31:0] o_out_value;
    logic [1:0]         o_status;
    logic               o_last;

    // predictor state: both lists and the dimension registers
    t_entry      pred_a[$];
    t_entry      pred_b[$];
    logic [15:0] dim_rows_a = '0;
    logic [15:0] dim_cols_a = '0;
    logic [15:0] dim_rows_b = '0;
    logic [15:0] dim_cols_b = '0;

    cmd_word_t cmd_q[$];
    cmd_word_t cur_cmd;
    sum_word_t pending_sums[$];
    int        gap_left = 0;
    bit        steady_feed = 1'b0;
    int        err_cnt = 0;

    sparse_coo_matrix_add_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    always #10 i_clk = ~i_clk;

    // append one sum word, last cleared
    function automatic void add_sum(input t_entry e, input logic [1:0] st);
        sum_word_t s;
        s.row    = 16'(e.row);
        s.col    = 16'(e.col);
        s.value  = e.value;
        s.status = st;
        s.last   = 1'b0;
        pending_sums.push_back(s);
    endfunction

    // update the lists for one command word and predict the sums it causes
    function automatic void predict_sums(input cmd_word_t w);
        t_entry e;
        t_entry ha;
        t_entry hb;
        int     ia;
        int     ib;
        int     n0;
        e.row   = w.row[COORD_BITS-1:0];
        e.col   = w.col[COORD_BITS-1:0];
        e.value = w.value;
        case (w.action)
            ACT_LOAD_A: begin
                if (pred_a.size() < DEPTH) pred_a.push_back(e);
            end
            ACT_LOAD_B: begin
                if (pred_b.size() < DEPTH) pred_b.push_back(e);
            end
            ACT_START: begin
                n0 = pending_sums.size();
                if (dim_rows_a != dim_rows_b || dim_cols_a != dim_cols_b) begin
                    add_sum('0, STAT_MISMATCH);
                end else begin
                    ia = 0;
                    ib = 0;
                    // merge on the heads, row first then column
                    while (ia < pred_a.size() && ib < pred_b.size()) begin
                        ha = pred_a[ia];
                        hb = pred_b[ib];
                        if ({ha.row, ha.col} < {hb.row, hb.col}) begin
                            add_sum(ha, STAT_OK);
                            ia++;
                        end else if ({ha.row, ha.col} > {hb.row, hb.col}) begin
                            add_sum(hb, STAT_OK);
                            ib++;
                        end else begin
                            ha.value = ha.value + hb.value;
                            add_sum(ha, STAT_OK);
                            ia++;
                            ib++;
                        end
                    end
                    // copy the tails
                    for (; ia < pred_a.size(); ia++) add_sum(pred_a[ia], STAT_OK);
                    for (; ib < pred_b.size(); ib++) add_sum(pred_b[ib], STAT_OK);
                    if (pending_sums.size() == n0) add_sum('0, STAT_EMPTY);
                end
                pending_sums[pending_sums.size()-1].last = 1'b1;
                pred_a.delete();
                pred_b.delete();
            end
            default: ;
        endcase
    endfunction

    task automatic note_error(input string msg);
        if (err_cnt < 10) $display("%t ERROR: %s", $realtime, msg);
        err_cnt++;
    endtask

    // command driver: present words from the queue, idle in random bursts
    always @(posedge i_clk) begin : cmd_driver
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) predict_sums(cur_cmd);
            if (start && busy) begin
                // hold the word until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                start <= 1'b0;
            end else if (!steady_feed && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
                start <= 1'b0;
            end else begin
                cur_cmd = cmd_q.pop_front();
                i_action <= cur_cmd.action;
                i_row    <= cur_cmd.row;
                i_col    <= cur_cmd.col;
                i_value  <= cur_cmd.value;
                start    <= 1'b1;
            end
        end
    end

    // result monitor: compare each strobed word with the oldest prediction
    always @(posedge i_clk) begin : sum_monitor
        sum_word_t got;
        sum_word_t want;
        if (i_rst_n && o_strobe) begin
            got = '{o_out_row, o_out_col, o_out_value, o_status, o_last};
            if (pending_sums.size() == 0) begin
                note_error($sformatf("unexpected word row=%h col=%h value=%h status=%0d last=%b",
                                     got.row, got.col, got.value, got.status, got.last));
            end else begin
                want = pending_sums.pop_front();
                if (got !== want) begin
                    note_error($sformatf({"word mismatch: expected row=%h col=%h value=%h ",
                                          "status=%0d last=%b, got row=%h col=%h value=%h ",
                                          "status=%0d last=%b"},
                                         want.row, want.col, want.value, want.status,
                                         want.last, got.row, got.col, got.value,
                                         got.status, got.last));
                end
            end
        end
    end

    task automatic push_cmd(input logic [1:0] act, input logic [15:0] r, input logic [15:0] c,
                            input logic [31:0] v);
        cmd_q.push_back('{act, r, c, v});
    endtask

    // queue one load sequence into both lists followed by a start
    task automatic queue_merge_group(input bit wide, input int max_len);
        int          na;
        int          nb;
        int          ia;
        int          ib;
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] step_max;
        na       = $urandom_range(0, max_len);
        nb       = $urandom_range(0, max_len);
        step_max = wide ? 32'h0800_0000 : 32'd3;
        key_a    = wide ? $urandom : $urandom_range(0, 15);
        key_b    = ($urandom_range(0, 3) == 0) ? $urandom : key_a;
        ia       = 0;
        ib       = 0;
        while (ia < na || ib < nb) begin
            // drop in an ignored word now and then
            if ($urandom_range(0, 19) == 0)
                push_cmd(ACT_NONE, 16'($urandom), 16'($urandom), $urandom);
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                push_cmd(ACT_LOAD_A, key_a[31:16], key_a[15:0], $urandom);
                key_a += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, step_max);
                ia++;
            end else begin
                push_cmd(ACT_LOAD_B, key_b[31:16], key_b[15:0], $urandom);
                key_b += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, step_max);
                ib++;
            end
        end
        push_cmd(ACT_START, 16'($urandom), 16'($urandom), $urandom);
    endtask

    // wait until the block has drained, then give loads time to settle
    task automatic wait_idle();
        while (cmd_q.size() != 0 || start || busy || pending_sums.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // write all four dimension registers back to back
    task automatic set_dims(input logic [15:0] ra, input logic [15:0] ca,
                            input logic [15:0] rb, input logic [15:0] cb);
        logic [1:0]  idx[4];
        logic [15:0] val[4];
        idx = '{REG_ROWS_A, REG_COLS_A, REG_ROWS_B, REG_COLS_B};
        val = '{ra, ca, rb, cb};
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                REG_ROWS_A: dim_rows_a = val[k];
                REG_COLS_A: dim_cols_a = val[k];
                REG_ROWS_B: dim_rows_b = val[k];
                REG_COLS_B: dim_cols_b = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] dims[4];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset dimensions
        push_cmd(ACT_START, 16'hffff, 16'hffff, 32'hffff_ffff);
        push_cmd(ACT_LOAD_A, 16'd0, 16'd0, 32'd1);
        push_cmd(ACT_LOAD_B, 16'd0, 16'd0, 32'hffff_ffff);
        push_cmd(ACT_START, 16'd0, 16'd0, 32'd0);
        push_cmd(ACT_LOAD_A, 16'd0, 16'd5, 32'h8000_0000);
        push_cmd(ACT_LOAD_A, 16'hffff, 16'hffff, 32'h7fff_ffff);
        push_cmd(ACT_LOAD_B, 16'd0, 16'd3, 32'd5);
        push_cmd(ACT_LOAD_B, 16'hffff, 16'hffff, 32'd1);
        push_cmd(ACT_NONE, 16'hffff, 16'hffff, 32'hffff_ffff);
        push_cmd(ACT_START, 16'd0, 16'd0, 32'd0);
        push_cmd(ACT_LOAD_B, 16'd2, 16'd2, 32'd7);
        push_cmd(ACT_START, 16'd0, 16'd0, 32'd0);
        push_cmd(ACT_LOAD_A, 16'd9, 16'd1, 32'd3);
        push_cmd(ACT_LOAD_A, 16'd1, 16'd9, 32'hffff_fffd);
        push_cmd(ACT_LOAD_B, 16'd5, 16'd5, 32'd11);
        push_cmd(ACT_START, 16'd0, 16'd0, 32'd0);

        // small equal dimensions, mostly dense key ranges
        set_dims(16'd0, 16'd0, 16'd0, 16'd0);
        set_dims(16'd12, 16'd9, 16'd12, 16'd9);
        for (int g = 0; g < 4; g++) queue_merge_group($urandom_range(0, 3) == 0, 8);

        // one register off at a time, so each start must report a mismatch
        for (int k = 0; k < 4; k++) begin
            dims    = '{16'd300, 16'd300, 16'd300, 16'd300};
            dims[k] = 16'hffff;
            set_dims(dims[0], dims[1], dims[2], dims[3]);
            queue_merge_group(1'b0, 4);
        end

        // full-scale dimensions, including lists that overflow
        set_dims(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_merge_group(1'b1, 40);
        queue_merge_group(1'b0, 40);

        // last stretch without idling
        set_dims(16'd0, 16'hffff, 16'd0, 16'hffff);
        steady_feed = 1'b1;
        for (int g = 0; g < 3; g++) queue_merge_group($urandom_range(0, 1) == 1, 8);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // end a hung run
    initial begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
